>>> design/pqbp_pkg.sv
// Shared types, constants and a helper function for the pixel quantize bit packer.
`timescale 1ns / 1ps

package pqbp_pkg;

    localparam int unsigned PixelWidth   = 8;
    localparam int unsigned ProductWidth = 2 * PixelWidth;
    localparam int unsigned OutFifoDepth = 4;
    localparam logic [PixelWidth-1:0] MaxLevelReset = 8'd255;

    typedef struct packed {
        logic [PixelWidth-1:0] pixel;
        logic                  last_pixel;
    } pqbp_in_t;

    typedef struct packed {
        logic [PixelWidth-1:0] packed_byte;
        logic                  last_byte;
    } pqbp_out_t;

    // Multiplier stage to packer stage
    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic [ProductWidth-1:0] product;
    } pqbp_prod_t;

    // Packer to output queue: up to two bytes per pixel, first in order
    typedef struct packed {
        logic [1:0] count;
        pqbp_out_t  first;
        pqbp_out_t  second;
    } pqbp_emit_t;

    // Number of significant bits in an 8-bit value (0 to 8)
    function automatic logic [3:0] bit_length(input logic [PixelWidth-1:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < PixelWidth; i++)
        begin
            if (v[i])
            begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> design/pixel_quantize_bit_packer.sv
// Top level of the pixel quantize bit packer.
//
// Usage:
//   Pixel channel: pixel_valid / pixel_stall / pixel_word carry one 8-bit grey
//   pixel per word with a last_pixel flag on the final pixel of an image.
//   Byte channel: byte_valid / byte_stall / byte_word carry packed bytes, codes
//   MSB first, last_byte set on the final byte of an image.
//   Config: cfg_valid / cfg_ready / cfg_data write max_level (reset 255); code
//   width is its bit length. cfg_ready is always high; write only when idle.
//   A pixel passes the input register and the product register, then its bytes
//   go into the queue. One pixel per cycle while pixel_stall is low; a
//   pixel gives zero, one or two bytes (two only when the last pixel splits).
//   Bytes drain through a small queue at one per cycle while byte_stall is low,
//   and pixel_stall rises when the queue cannot take two more.
//   The receiver may hold byte_stall for any time; the queued word holds.
//   Reset clears the pipeline, the queue and the partial byte; max_level 255.
`timescale 1ns / 1ps

module pixel_quantize_bit_packer #(
    parameter int unsigned FIFO_DEPTH = pqbp_pkg::OutFifoDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  pqbp_pkg::pqbp_in_t pixel_word,
    output logic               byte_valid,
    input  logic               byte_stall,
    output pqbp_pkg::pqbp_out_t byte_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import pqbp_pkg::*;

    logic [7:0] max_level_reg;
    logic       advance;
    pqbp_prod_t prod;
    pqbp_emit_t emit;

    assign cfg_ready   = 1'b1;
    assign pixel_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_level_reg <= MaxLevelReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_level_reg <= cfg_data;
        end
    end

    pqbp_quant u_quant (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (pixel_valid),
        .in_word   (pixel_word),
        .max_level (max_level_reg),
        .prod      (prod)
    );

    pqbp_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .prod      (prod),
        .max_level (max_level_reg),
        .emit      (emit)
    );

    pqbp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .has_room  (advance),
        .out_valid (byte_valid),
        .out_stall (byte_stall),
        .out_word  (byte_word)
    );

endmodule

>>> design/pqbp_quant.sv
// Input register and pixel times max_level multiplier stage.
`timescale 1ns / 1ps

module pqbp_quant (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  pqbp_pkg::pqbp_in_t in_word,
    input  logic [7:0]        max_level,
    output pqbp_pkg::pqbp_prod_t prod
);
    import pqbp_pkg::*;

    logic     s1_valid_reg;
    pqbp_in_t s1_word_reg;
    logic     s2_valid_reg;
    logic     s2_last_reg;
    logic [ProductWidth-1:0] s2_product_reg;
    logic [ProductWidth-1:0] product_next;

    assign product_next = s1_word_reg.pixel * max_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_word_reg    <= in_word;
            s2_last_reg    <= s1_word_reg.last_pixel;
            s2_product_reg <= product_next;
        end
    end

    assign prod.valid   = s2_valid_reg;
    assign prod.last    = s2_last_reg;
    assign prod.product = s2_product_reg;

endmodule

>>> design/pqbp_pack.sv
// Divide by 255, MSB-first bit packing and end-of-image flush.
`timescale 1ns / 1ps

module pqbp_pack (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  pqbp_pkg::pqbp_prod_t prod,
    input  logic [7:0]           max_level,
    output pqbp_pkg::pqbp_emit_t emit
);
    import pqbp_pkg::*;

    logic [7:0]  partial_byte_reg;
    logic [7:0]  partial_byte_next;
    logic [2:0]  bits_filled_reg;
    logic [2:0]  bits_filled_next;

    logic [3:0]  code_width;
    logic [16:0] div_sum;
    logic [7:0]  code;
    logic [3:0]  total;
    logic [4:0]  shift;
    logic [23:0] shifted;
    logic [15:0] word;
    logic        full;
    logic [7:0]  mid_byte;
    logic [2:0]  mid_bits;
    logic        flush;
    logic        fire;

    assign code_width = bit_length(max_level);

    // x / 255 == (x + (x >> 8) + 1) >> 8 over the product range
    assign div_sum = {1'b0, prod.product} + 17'(prod.product[15:8]) + 17'd1;
    assign code    = div_sum[15:8];

    assign total   = {1'b0, bits_filled_reg} + code_width;
    assign shift   = 5'd16 - {1'b0, total};
    assign shifted = {16'd0, code} << shift;
    assign word    = {partial_byte_reg, 8'd0} | shifted[15:0];

    assign full     = (total >= 4'd8);
    assign mid_byte = full ? word[7:0] : word[15:8];
    // remainder after a completed byte is the low three bits either way
    assign mid_bits = total[2:0];
    assign flush    = prod.last && (mid_bits != 3'd0);
    assign fire     = prod.valid && advance;

    always_comb
    begin
        emit.count              = 2'd0;
        emit.first.packed_byte  = word[15:8];
        emit.first.last_byte    = 1'b0;
        emit.second.packed_byte = mid_byte;
        emit.second.last_byte   = 1'b1;
        if (fire)
        begin
            if (full && flush)
            begin
                emit.count = 2'd2;
            end
            else if (full)
            begin
                emit.count           = 2'd1;
                emit.first.last_byte = prod.last;
            end
            else if (flush)
            begin
                emit.count              = 2'd1;
                emit.first.packed_byte  = mid_byte;
                emit.first.last_byte    = 1'b1;
            end
        end
    end

    always_comb
    begin
        partial_byte_next = partial_byte_reg;
        bits_filled_next  = bits_filled_reg;
        if (fire)
        begin
            if (prod.last)
            begin
                partial_byte_next = 8'd0;
                bits_filled_next  = 3'd0;
            end
            else
            begin
                partial_byte_next = mid_byte;
                bits_filled_next  = mid_bits;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_byte_reg <= 8'd0;
            bits_filled_reg  <= 3'd0;
        end
        else
        begin
            partial_byte_reg <= partial_byte_next;
            bits_filled_reg  <= bits_filled_next;
        end
    end

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && prod.last) |=> (bits_filled_reg == 3'd0 && partial_byte_reg == 8'd0))
        else $error("packer state not cleared after last pixel");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (partial_byte_reg & (8'hFF >> bits_filled_reg)) == 8'd0)
        else $error("unused bits of partial byte not zero");

endmodule

>>> design/pqbp_fifo.sv
// Small output queue taking up to two bytes a cycle and giving one while out_stall is low.
`timescale 1ns / 1ps

module pqbp_fifo #(
    parameter int unsigned DEPTH = pqbp_pkg::OutFifoDepth
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pqbp_pkg::pqbp_emit_t emit,
    output logic                 has_room,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pqbp_pkg::pqbp_out_t  out_word
);
    import pqbp_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    pqbp_out_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [PW-1:0]   wr_ptr_plus1;
    logic            pop;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        if (p == PW'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + PW'(1);
        end
        return n;
    endfunction

    assign wr_ptr_plus1 = next_ptr(wr_ptr_reg);
    assign pop          = out_valid && !out_stall;
    // room for the worst case of two bytes from one pixel
    assign has_room     = (count_reg <= CW'(DEPTH - 2));
    assign out_valid    = (count_reg != '0);
    assign out_word     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        case (emit.count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = next_ptr(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? next_ptr(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(emit.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (emit.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= emit.first;
        end
        if (emit.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= emit.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.count != 2'd0) |-> has_room)
        else $error("bytes written into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

>>> verif/pixel_quantize_bit_packer_checker.sv
// Checker for the pixel quantize bit packer: predicts packed bytes and compares them.
`timescale 1ns / 1ps

module pixel_quantize_bit_packer_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pixel_valid,
    input  logic                pixel_stall,
    input  pqbp_pkg::pqbp_in_t  pixel_word,
    input  logic                byte_valid,
    input  logic                byte_stall,
    input  pqbp_pkg::pqbp_out_t byte_word,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    output int unsigned         fail_count,
    output int unsigned         pending
);

    logic [7:0]          level;
    logic [7:0]          pend_bits;
    logic [2:0]          pend_count;
    pqbp_pkg::pqbp_out_t expected_bytes[$];
    pqbp_pkg::pqbp_out_t want;

    function automatic logic [3:0] code_width(input logic [7:0] lvl);
        logic [3:0] w;
        logic [7:0] v;
        w = 4'd0;
        v = lvl;
        while (v != 8'd0)
        begin
            w++;
            v = v >> 1;
        end
        return w;
    endfunction

    // Requantize one pixel, append its code to the pending bits and queue
    // whatever bytes it completes or flushes.
    function automatic void quantize_and_pack(input logic [7:0] pix, input logic last);
        logic [15:0]         prod;
        logic [7:0]          code;
        logic [4:0]          total;
        logic [15:0]         acc;
        pqbp_pkg::pqbp_out_t b;
        prod  = 16'(pix) * 16'(level);
        code  = 8'(prod / 16'd255);
        total = 5'(pend_count) + 5'(code_width(level));
        acc   = {pend_bits, 8'h00} | (16'(code) << (5'd16 - total));
        if (total >= 5'd8)
        begin
            b.packed_byte = acc[15:8];
            b.last_byte   = last && (total == 5'd8);
            expected_bytes.push_back(b);
            pend_bits  = acc[7:0];
            pend_count = 3'(total - 5'd8);
        end
        else
        begin
            pend_bits  = acc[15:8];
            pend_count = total[2:0];
        end
        if (last)
        begin
            if (pend_count != 3'd0)
            begin
                b.packed_byte = pend_bits;
                b.last_byte   = 1'b1;
                expected_bytes.push_back(b);
            end
            pend_bits  = 8'd0;
            pend_count = 3'd0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        if (fail_count < 40)
        begin
            $display("%0t: %s: got %02h, expected %02h", $time, what, got, exp_val);
        end
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level      = pqbp_pkg::MaxLevelReset;
            pend_bits  = 8'd0;
            pend_count = 3'd0;
            expected_bytes.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // output word is checked before this edge's pixel is predicted
            if (byte_valid && !byte_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("byte with none expected", byte_word.packed_byte, 8'h00);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (byte_word.packed_byte !== want.packed_byte)
                    begin
                        report_mismatch("packed_byte", byte_word.packed_byte,
                                        want.packed_byte);
                    end
                    if (byte_word.last_byte !== want.last_byte)
                    begin
                        report_mismatch("last_byte", 8'(byte_word.last_byte),
                                        8'(want.last_byte));
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                level = cfg_data;
            end
            if (pixel_valid && !pixel_stall)
            begin
                quantize_and_pack(pixel_word.pixel, pixel_word.last_pixel);
            end
            pending = expected_bytes.size();
        end
    end

endmodule

>>> verif/pixel_quantize_bit_packer_tb.sv
// Testbench top for the pixel quantize bit packer: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module pixel_quantize_bit_packer_tb;

    localparam int unsigned RandomPixels = 1350;
    localparam int unsigned HoldCycles   = 200;
    localparam int unsigned IdleLimit    = 2000;

    logic                clk;
    logic                rst_n;
    logic                pixel_valid;
    logic                pixel_stall;
    pqbp_pkg::pqbp_in_t  pixel_word;
    logic                byte_valid;
    logic                byte_stall;
    pqbp_pkg::pqbp_out_t byte_word;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [7:0]          cfg_data;
    int unsigned         fail_count;
    int unsigned         pending;

    int unsigned pixels_sent;
    bit          steady;
    bit          hold_req;
    bit          hold_done;

    pixel_quantize_bit_packer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_word  (pixel_word),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_word   (byte_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    pixel_quantize_bit_packer_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_word  (pixel_word),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_word   (byte_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return 0;
        end
        else if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] pix, input logic last);
        int unsigned gap;
        pixel_valid <= 1'b1;
        pixel_word  <= '{pixel: pix, last_pixel: last};
        @(posedge clk);
        while (pixel_stall)
        begin
            @(posedge clk);
        end
        pixels_sent++;
        gap = steady ? 0 : idle_len();
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // max_level only changes once every queued byte is out and the pipe is empty
    task automatic write_level(input logic [7:0] lvl);
        pixel_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lvl;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_image(input int unsigned len, input bit close);
        for (int unsigned k = 0; k < len; k++)
        begin
            send_pixel(pick_pixel(), close && (k == len - 1));
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned left;
        left = 0;
        byte_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                byte_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                hold_done = 1'b1;
                byte_stall <= 1'b0;
            end
            else
            begin
                if (left == 0 && !steady && $urandom_range(0, 4) == 0)
                begin
                    left = idle_len();
                end
                if (left != 0)
                begin
                    byte_stall <= 1'b1;
                    left--;
                end
                else
                begin
                    byte_stall <= 1'b0;
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (byte_valid && !byte_stall)
                || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= IdleLimit)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned n_img;
        int unsigned len;
        logic [7:0]  lvl;
        phase       = 0;
        pixels_sent = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        rst_n       = 1'b0;
        pixel_valid <= 1'b0;
        pixel_word  <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= 8'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full width after reset; third code fills a byte exactly on the last pixel
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hff, 1'b0);
        send_pixel(8'h80, 1'b1);
        // 3-bit codes: last pixel completes a byte and leaves one bit over
        write_level(8'd7);
        send_pixel(8'hff, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hff, 1'b1);
        // 4-bit codes: byte completed on the last pixel
        write_level(8'd15);
        send_pixel(8'hff, 1'b0);
        send_pixel(8'h11, 1'b1);
        // 1-bit codes: short partial byte flushed
        write_level(8'd1);
        send_pixel(8'hff, 1'b0);
        send_pixel(8'hfe, 1'b0);
        send_pixel(8'hff, 1'b1);
        // zero level: no bits, nothing emitted
        write_level(8'd0);
        send_pixel(8'hc8, 1'b0);
        send_pixel(8'hff, 1'b1);
        // pending bits left from 2-bit codes, flushed under zero level
        write_level(8'd3);
        send_pixel(8'hff, 1'b0);
        write_level(8'd0);
        send_pixel(8'h0a, 1'b1);
        write_level(8'd128);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'haa, 1'b1);
        write_level(8'd255);
        send_pixel(8'h55, 1'b0);
        send_pixel(8'haa, 1'b1);

        while (pixels_sent < RandomPixels + 20)
        begin
            phase++;
            if (phase == 4)
            begin
                // back-pressure: receiver holds while the sender keeps offering
                write_level(8'd255);
                steady   = 1'b1;
                hold_req = 1'b1;
                send_image(60, 1'b1);
                steady = 1'b0;
            end
            case ($urandom_range(0, 9))
                0: lvl = 8'd0;
                1: lvl = 8'd1;
                2: lvl = 8'd255;
                3: lvl = 8'd128;
                4: lvl = 8'd127;
                default: lvl = 8'($urandom_range(1, 255));
            endcase
            write_level(lvl);
            steady = ($urandom_range(0, 3) == 0);
            n_img  = $urandom_range(1, 4);
            for (int unsigned i = 0; i < n_img; i++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 16);
                // now and then an image runs on without its last flag
                send_image(len, $urandom_range(0, 9) != 0);
            end
            steady = 1'b0;
        end
        pixel_valid <= 1'b0;

        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
design/pqbp_pkg.sv
design/pqbp_quant.sv
design/pqbp_pack.sv
design/pqbp_fifo.sv
design/pixel_quantize_bit_packer.sv
verif/pixel_quantize_bit_packer_checker.sv
verif/pixel_quantize_bit_packer_tb.sv
